// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants and types for the positional list engine: sizes, request
// codes, status codes and the memory access bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int CNT_OUT_W = 6;

  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_HD  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE_AT  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE_HD  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/ple_mem.sv =====
// ----------------------------------------------------------------------------
// ple_mem
// Entry store: one write port and one read port, read data registered and
// held until the next read.
// ----------------------------------------------------------------------------
module ple_mem
  import ple_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words addressed by position, kept in one
// synchronous memory and updated by shifting entries one per cycle.
// ----------------------------------------------------------------------------
// One request is taken at a time; the request channel stalls until its last
// result word has been loaded into the output register. Inserts move entries
// up one place and deletes move them down one place, each moved entry read
// and then written back. Readout streams one entry per cycle while the result
// side does not stall. The single read and single write port of the entry
// memory set this pace: each moved entry needs one read and one write.
// Invalid requests and full-store inserts answer with a status word and
// change nothing.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [POS_W-1:0]     position,
  input  logic signed [DATA_W-1:0] value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [STATUS_W-1:0]  status,
  output logic                 has_value,
  output logic signed [DATA_W-1:0] entry_value,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic                 last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]          state, state_next;
  logic [COUNT_W-1:0]  total, total_next;
  logic [COUNT_W-1:0]  cur, cur_next;
  logic [ADDR_W-1:0]   ins_pos, ins_pos_next;
  logic [DATA_W-1:0]   ins_val, ins_val_next;
  logic                wr_pend, wr_pend_next;
  logic [ADDR_W-1:0]   wr_addr, wr_addr_next;
  logic                rd_valid, rd_valid_next;
  logic [STATUS_W-1:0] rsp_code, rsp_code_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_has;
  logic [DATA_W-1:0]   out_value;
  logic [CNT_OUT_W-1:0] out_count;
  logic                out_last;

  logic                can_load;
  logic                load;
  logic [STATUS_W-1:0] ld_status;
  logic                ld_has;
  logic [DATA_W-1:0]   ld_value;
  logic                ld_last;

  logic                accept;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    total_ext;
  logic [COUNT_W-1:0]  ins_target;

  mem_req_t            mem_req;
  logic [DATA_W-1:0]   mem_rdata;

  ple_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign can_load  = !out_valid || !rsp_stall;
  assign pos_ext   = CMP_W'(position);
  assign total_ext = CMP_W'(total);

  always_comb begin
    unique case (operation)
      OP_APPEND:    ins_target = total;
      OP_INSERT_AT: ins_target = COUNT_W'(position);
      default:      ins_target = '0;
    endcase
  end

  always_comb begin
    state_next    = state;
    total_next    = total;
    cur_next      = cur;
    ins_pos_next  = ins_pos;
    ins_val_next  = ins_val;
    wr_pend_next  = wr_pend;
    wr_addr_next  = wr_addr;
    rd_valid_next = rd_valid;
    rsp_code_next = rsp_code;
    mem_req       = '0;
    load          = 1'b0;
    ld_status     = ST_OK;
    ld_has        = 1'b0;
    ld_value      = '0;
    ld_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          wr_pend_next  = 1'b0;
          rd_valid_next = 1'b0;
          case (operation) inside
            OP_APPEND, OP_INSERT_AT, OP_INSERT_HD: begin
              if (operation == OP_INSERT_AT && pos_ext > total_ext) begin
                rsp_code_next = ST_INVALID;
                state_next    = S_RESP;
              end else if (total >= COUNT_W'(CAPACITY)) begin
                rsp_code_next = ST_FULL;
                state_next    = S_RESP;
              end else begin
                cur_next     = total;
                ins_pos_next = ADDR_W'(ins_target);
                ins_val_next = value;
                state_next   = S_INS;
              end
            end
            OP_DELETE_AT: begin
              if (pos_ext >= total_ext) begin
                rsp_code_next = ST_INVALID;
                state_next    = S_RESP;
              end else begin
                cur_next   = COUNT_W'(position);
                state_next = S_DEL;
              end
            end
            OP_DELETE_HD: begin
              if (total == '0) begin
                rsp_code_next = ST_INVALID;
                state_next    = S_RESP;
              end else begin
                cur_next   = '0;
                state_next = S_DEL;
              end
            end
            OP_READ_ALL: begin
              if (total == '0) begin
                rsp_code_next = ST_OK;
                state_next    = S_RESP;
              end else begin
                cur_next   = '0;
                state_next = S_READ;
              end
            end
            default: begin
              rsp_code_next = ST_INVALID;
              state_next    = S_RESP;
            end
          endcase
        end
      end

      // move entries up, top first: read i-1 now, write it to i next cycle
      S_INS: begin
        mem_req.we    = wr_pend;
        mem_req.waddr = wr_addr;
        mem_req.wdata = mem_rdata;
        if (cur > COUNT_W'(ins_pos)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(cur - 1'b1);
          wr_addr_next  = ADDR_W'(cur);
          wr_pend_next  = 1'b1;
          cur_next      = cur - 1'b1;
        end else begin
          wr_pend_next = 1'b0;
          if (!wr_pend) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ins_pos;
            mem_req.wdata = ins_val;
            total_next    = total + 1'b1;
            rsp_code_next = ST_OK;
            state_next    = S_RESP;
          end
        end
      end

      // move entries down: read i+1 now, write it to i next cycle
      S_DEL: begin
        mem_req.we    = wr_pend;
        mem_req.waddr = wr_addr;
        mem_req.wdata = mem_rdata;
        if (cur + 1'b1 < total) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(cur + 1'b1);
          wr_addr_next  = ADDR_W'(cur);
          wr_pend_next  = 1'b1;
          cur_next      = cur + 1'b1;
        end else begin
          wr_pend_next  = 1'b0;
          total_next    = total - 1'b1;
          rsp_code_next = ST_OK;
          state_next    = S_RESP;
        end
      end

      // rd_valid: mem_rdata holds entry cur-1
      S_READ: begin
        if (rd_valid && can_load) begin
          load      = 1'b1;
          ld_status = ST_OK;
          ld_has    = 1'b1;
          ld_value  = mem_rdata;
          ld_last   = (cur == total);
        end
        if ((!rd_valid || load) && cur < total) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(cur);
          cur_next      = cur + 1'b1;
          rd_valid_next = 1'b1;
        end else if (load) begin
          rd_valid_next = 1'b0;
        end
        if (load && ld_last) begin
          state_next = S_IDLE;
        end
      end

      S_RESP: begin
        if (can_load) begin
          load       = 1'b1;
          ld_status  = rsp_code;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      total    <= '0;
      wr_pend  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      total    <= total_next;
      wr_pend  <= wr_pend_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    ins_pos  <= ins_pos_next;
    ins_val  <= ins_val_next;
    wr_addr  <= wr_addr_next;
    rsp_code <= rsp_code_next;
  end

  // output register: parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_has    <= ld_has;
      out_value  <= ld_value;
      out_count  <= CNT_OUT_W'(total_next);
      out_last   <= ld_last;
    end
  end

  assign rsp_valid   = out_valid;
  assign status      = out_status;
  assign has_value   = out_has;
  assign entry_value = out_value;
  assign entry_count = out_count;
  assign last        = out_last;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    total <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && total != $past(total)) |->
      (total == $past(total) + 1'b1 || total + 1'b1 == $past(total)))
    else $error("entry count moved by more than one");

  a_port_clash : assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write of the same entry in one cycle");

  a_load_room : assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || !rsp_stall))
    else $error("result word loaded over a held word");

endmodule

// ===== tb/positional_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. Request words come from
// a queue filled up front (a directed opening, then random runs that swing
// between filling and draining the list) and are sent with random gaps. Every
// accepted request is applied to a queue-based copy of the list, and each
// result word is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
  import ple_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 460;
  localparam int DRAIN_CYCLES    = 60;
  localparam int LIMIT_CYCLES    = 3_000_000;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [DATA_W-1:0] val;
    bit                      hold;
  } list_request_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic                     has_value;
    logic signed [DATA_W-1:0] entry_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     last;
  } list_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [OP_W-1:0]          operation = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic                     has_value;
  logic signed [DATA_W-1:0] entry_value;
  logic [CNT_OUT_W-1:0]     entry_count;
  logic                     last;

  list_request_t            pending_requests[$];
  list_word_t               expected_words[$];
  logic signed [DATA_W-1:0] model_entries[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int planned_count = 0;
  bit req_taken = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int stall_calm = 0;

  positional_list_engine dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .position(position),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .has_value(has_value),
    .entry_value(entry_value),
    .entry_count(entry_count),
    .last(last)
  );

  always #5 clk = ~clk;

  // mostly short, a few long, and now and then a calm stretch with none
  function automatic int idle_length(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(10, 40);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string field, longint got, longint want);
    $display("t=%0t %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  function automatic logic [STATUS_W-1:0] model_insert(int at, logic signed [DATA_W-1:0] v);
    if (at > model_entries.size()) return ST_INVALID;
    if (model_entries.size() >= CAPACITY) return ST_FULL;
    model_entries.insert(at, v);
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] model_delete(int at);
    if (at >= model_entries.size()) return ST_INVALID;
    model_entries.delete(at);
    return ST_OK;
  endfunction

  function automatic void apply_list_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                             logic signed [DATA_W-1:0] v);
    list_word_t w;
    int n;
    w = '{ST_INVALID, 1'b0, '0, '0, 1'b1};
    case (op)
      OP_APPEND:    w.status = model_insert(model_entries.size(), v);
      OP_INSERT_AT: w.status = model_insert(int'(pos), v);
      OP_INSERT_HD: w.status = model_insert(0, v);
      OP_DELETE_AT: w.status = model_delete(int'(pos));
      OP_DELETE_HD: w.status = model_delete(0);
      OP_READ_ALL: begin
        n = model_entries.size();
        w.status = ST_OK;
        for (int i = 0; i < n; i++) begin
          w.has_value   = 1'b1;
          w.entry_value = model_entries[i];
          w.entry_count = CNT_OUT_W'(n);
          w.last        = (i == n - 1);
          expected_words.push_back(w);
        end
        // an empty list still answers with one empty word
        if (n != 0) return;
      end
      default: w.status = ST_INVALID;
    endcase
    w.entry_count = CNT_OUT_W'(model_entries.size());
    expected_words.push_back(w);
  endfunction

  // queues one request and tracks the list length it leaves behind
  task automatic plan_request(logic [OP_W-1:0] op, int pos, logic signed [DATA_W-1:0] v,
                              bit hold = 1'b0);
    list_request_t q;
    q = '{op, POS_W'(pos), v, hold};
    pending_requests.push_back(q);
    case (op) inside
      OP_APPEND, OP_INSERT_HD:
        if (planned_count < CAPACITY) planned_count++;
      OP_INSERT_AT:
        if (pos <= planned_count && planned_count < CAPACITY) planned_count++;
      OP_DELETE_AT:
        if (pos < planned_count) planned_count--;
      OP_DELETE_HD:
        if (planned_count > 0) planned_count--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bit filling;
    int phase_left;
    int r;
    logic [OP_W-1:0] op;
    int pos;

    // directed opening: empty list, edges of position and value, spare codes
    plan_request(OP_READ_ALL, 0, 0);
    plan_request(OP_DELETE_HD, 0, 0);
    plan_request(OP_DELETE_AT, 0, 0);
    plan_request(OP_INSERT_AT, 1, 32'sd5);
    plan_request(OP_INSERT_AT, 0, 32'sd0);
    plan_request(OP_APPEND, 0, 32'sh7fffffff);
    plan_request(OP_INSERT_HD, 0, 32'sh80000000);
    plan_request(OP_INSERT_AT, 3, -32'sd1);
    plan_request(OP_INSERT_AT, 5, 32'sd9);
    plan_request(OP_INSERT_AT, 63, 32'sd9);
    plan_request(OP_INSERT_AT, 2, 32'sh55555555);
    plan_request(OP_INSERT_AT, 1, 32'shaaaaaaaa, 1'b1);
    plan_request(OP_READ_ALL, 0, 0);
    plan_request(OP_DELETE_AT, 6, 0);
    plan_request(OP_DELETE_AT, 63, 0);
    plan_request(OP_DELETE_AT, 2, 0);
    plan_request(OP_SPARE_LO, 0, 0);
    plan_request(OP_SPARE_HI, 63, -32'sd1);
    plan_request(OP_DELETE_HD, 0, 0);
    plan_request(OP_DELETE_AT, planned_count - 1, 0);
    plan_request(OP_READ_ALL, 0, 0, 1'b1);

    // random runs alternate between growing the list to full and draining it
    filling = 1'b1;
    phase_left = $urandom_range(40, 80);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        filling = ~filling;
        phase_left = $urandom_range(30, 80);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (filling)
        op = (r < 30) ? OP_APPEND : (r < 55) ? OP_INSERT_AT : (r < 75) ? OP_INSERT_HD :
             (r < 80) ? OP_DELETE_AT : (r < 83) ? OP_DELETE_HD : (r < 96) ? OP_READ_ALL :
             (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
      else
        op = (r < 5) ? OP_APPEND : (r < 10) ? OP_INSERT_AT : (r < 15) ? OP_INSERT_HD :
             (r < 45) ? OP_DELETE_AT : (r < 72) ? OP_DELETE_HD : (r < 94) ? OP_READ_ALL :
             (r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
      pos = $urandom_range(0, 63);
      if (op == OP_INSERT_AT && $urandom_range(0, 99) < 85)
        pos = $urandom_range(0, planned_count);
      else if (op == OP_DELETE_AT && planned_count > 0 && $urandom_range(0, 99) < 85)
        pos = $urandom_range(0, planned_count - 1);
      plan_request(op, pos, random_value(), $urandom_range(0, 49) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() != 0 || req_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // request driver: a held word stays put until it is taken
  always @(negedge clk) begin
    list_request_t next;
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (send_gap > 0) begin
          req_valid <= 1'b0;
          send_gap--;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].hold && expected_words.size() != 0)) begin
          next = pending_requests.pop_front();
          operation <= next.op;
          position  <= next.pos;
          value     <= next.val;
          req_valid <= 1'b1;
          send_gap = idle_length(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
      stall_left = idle_length(stall_calm);
    end
  end

  always @(posedge clk) begin
    list_word_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        apply_list_request(operation, position, value);
        req_taken = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("unexpected result word, status", status, -1);
        end else begin
          want = expected_words.pop_front();
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (has_value !== want.has_value)
            flag_mismatch("has_value", has_value, want.has_value);
          if (entry_value !== want.entry_value)
            flag_mismatch("entry_value", entry_value, want.entry_value);
          if (entry_count !== want.entry_count)
            flag_mismatch("entry_count", entry_count, want.entry_count);
          if (last !== want.last) flag_mismatch("last", last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
